### rtl/aabb_pkg.sv
// Shared types, constants and helpers of the AABB body step and resolve unit.
`timescale 1ns / 1ps

package aabb_pkg;

  // Number format of position and velocity: signed Q7.12
  localparam int VALUE_BITS = 20;
  localparam int FRAC_BITS  = 12;

  // Field widths
  localparam int DT_W     = 12;
  localparam int SIZE_W   = 19;
  localparam int GRAV_W   = 18;
  localparam int GROUND_W = 19;
  localparam int LIMIT_W  = 19;
  localparam int HALF_W   = 18;

  // Datapath widths
  localparam int MUL_A_W = VALUE_BITS + 1;
  localparam int MUL_B_W = DT_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int DIFF_W  = VALUE_BITS + 1;
  localparam int SPAN_W  = HALF_W + 1;

  localparam logic signed [SUM_W-1:0] VMAX_S =
    {{(SUM_W - VALUE_BITS + 1){1'b0}}, {(VALUE_BITS - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] VMIN_S =
    {{(SUM_W - VALUE_BITS + 1){1'b1}}, {(VALUE_BITS - 1){1'b0}}};

  // Register port
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_GRAVITY      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GROUND_LEVEL = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WORLD_LIMIT  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BODY_HALF_X  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BODY_HALF_Y  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BODY_HALF_Z  = 3'd5;

  localparam logic [GRAV_W-1:0]          RST_GRAVITY      = 18'd40141;
  localparam logic signed [GROUND_W-1:0] RST_GROUND_LEVEL = 19'sd2048;
  localparam logic [LIMIT_W-1:0]         RST_WORLD_LIMIT  = 19'd196608;
  localparam logic [HALF_W-1:0]          RST_BODY_HALF_X  = 18'd2048;
  localparam logic [HALF_W-1:0]          RST_BODY_HALF_Y  = 18'd1024;
  localparam logic [HALF_W-1:0]          RST_BODY_HALF_Z  = 18'd1638;

  // Item kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_OBST = 1'b1;

  // Datapath operations
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_IDLE     = 4'd0;
  localparam logic [OP_W-1:0] OP_GRAV     = 4'd1;
  localparam logic [OP_W-1:0] OP_VEL_X    = 4'd2;
  localparam logic [OP_W-1:0] OP_VEL_Y    = 4'd3;
  localparam logic [OP_W-1:0] OP_VEL_Z    = 4'd4;
  localparam logic [OP_W-1:0] OP_ADD_Z    = 4'd5;
  localparam logic [OP_W-1:0] OP_CLAMP    = 4'd6;
  localparam logic [OP_W-1:0] OP_OBS_DIFF = 4'd7;
  localparam logic [OP_W-1:0] OP_OBS_TEST = 4'd8;
  localparam logic [OP_W-1:0] OP_OBS_PUSH = 4'd9;
  localparam logic [OP_W-1:0] OP_EMIT     = 4'd10;

  typedef struct packed {
    logic            load_in;
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic out_hold;
  } status_t;

  typedef struct packed {
    logic [GRAV_W-1:0]          gravity;
    logic signed [GROUND_W-1:0] ground_level;
    logic [LIMIT_W-1:0]         world_limit;
    logic [HALF_W-1:0]          body_half_x;
    logic [HALF_W-1:0]          body_half_y;
    logic [HALF_W-1:0]          body_half_z;
  } cfg_t;

  // Saturate a wide signed sum to the value range
  function automatic logic signed [VALUE_BITS-1:0] sat_val(input logic signed [SUM_W-1:0] v);
    logic signed [VALUE_BITS-1:0] r;
    if (v > VMAX_S) begin
      r = VMAX_S[VALUE_BITS-1:0];
    end else if (v < VMIN_S) begin
      r = VMIN_S[VALUE_BITS-1:0];
    end else begin
      r = v[VALUE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/aabb_cfg.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module aabb_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [aabb_pkg::ADDR_W-1:0]  paddr,
  input  logic [aabb_pkg::DATA_W-1:0]  pwdata,
  output logic [aabb_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output aabb_pkg::cfg_t               cfg
);

  aabb_pkg::cfg_t                  cfg_r;
  logic [aabb_pkg::REG_IDX_W-1:0]  idx;
  logic                            wr_en;

  assign idx    = paddr[aabb_pkg::ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gravity      <= aabb_pkg::RST_GRAVITY;
      cfg_r.ground_level <= aabb_pkg::RST_GROUND_LEVEL;
      cfg_r.world_limit  <= aabb_pkg::RST_WORLD_LIMIT;
      cfg_r.body_half_x  <= aabb_pkg::RST_BODY_HALF_X;
      cfg_r.body_half_y  <= aabb_pkg::RST_BODY_HALF_Y;
      cfg_r.body_half_z  <= aabb_pkg::RST_BODY_HALF_Z;
    end else if (wr_en) begin
      unique case (idx)
        aabb_pkg::REG_GRAVITY:      cfg_r.gravity      <= pwdata[aabb_pkg::GRAV_W-1:0];
        aabb_pkg::REG_GROUND_LEVEL: cfg_r.ground_level <= pwdata[aabb_pkg::GROUND_W-1:0];
        aabb_pkg::REG_WORLD_LIMIT:  cfg_r.world_limit  <= pwdata[aabb_pkg::LIMIT_W-1:0];
        aabb_pkg::REG_BODY_HALF_X:  cfg_r.body_half_x  <= pwdata[aabb_pkg::HALF_W-1:0];
        aabb_pkg::REG_BODY_HALF_Y:  cfg_r.body_half_y  <= pwdata[aabb_pkg::HALF_W-1:0];
        aabb_pkg::REG_BODY_HALF_Z:  cfg_r.body_half_z  <= pwdata[aabb_pkg::HALF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      aabb_pkg::REG_GRAVITY:      prdata = aabb_pkg::DATA_W'(cfg_r.gravity);
      aabb_pkg::REG_GROUND_LEVEL: prdata = aabb_pkg::DATA_W'($signed(cfg_r.ground_level));
      aabb_pkg::REG_WORLD_LIMIT:  prdata = aabb_pkg::DATA_W'(cfg_r.world_limit);
      aabb_pkg::REG_BODY_HALF_X:  prdata = aabb_pkg::DATA_W'(cfg_r.body_half_x);
      aabb_pkg::REG_BODY_HALF_Y:  prdata = aabb_pkg::DATA_W'(cfg_r.body_half_y);
      aabb_pkg::REG_BODY_HALF_Z:  prdata = aabb_pkg::DATA_W'(cfg_r.body_half_z);
      default:                    prdata = '0;
    endcase
  end

endmodule

### rtl/aabb_ctrl.sv
// Sequencer that steps the datapath through a tick or an obstacle test.
`timescale 1ns / 1ps

module aabb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  input  aabb_pkg::status_t status,
  output logic              busy,
  output aabb_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GRAV  = 4'd1;
  localparam logic [3:0] S_VX    = 4'd2;
  localparam logic [3:0] S_VY    = 4'd3;
  localparam logic [3:0] S_VZ    = 4'd4;
  localparam logic [3:0] S_ADDZ  = 4'd5;
  localparam logic [3:0] S_CLAMP = 4'd6;
  localparam logic [3:0] S_ODIFF = 4'd7;
  localparam logic [3:0] S_OTEST = 4'd8;
  localparam logic [3:0] S_OPUSH = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0] state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.load_in = 1'b0;
    cmd.op      = aabb_pkg::OP_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = (in_kind == aabb_pkg::KIND_OBST) ? S_ODIFF : S_GRAV;
        end
      end
      S_GRAV: begin
        cmd.op    = aabb_pkg::OP_GRAV;
        state_nxt = S_VX;
      end
      S_VX: begin
        cmd.op    = aabb_pkg::OP_VEL_X;
        state_nxt = S_VY;
      end
      S_VY: begin
        cmd.op    = aabb_pkg::OP_VEL_Y;
        state_nxt = S_VZ;
      end
      S_VZ: begin
        cmd.op    = aabb_pkg::OP_VEL_Z;
        state_nxt = S_ADDZ;
      end
      S_ADDZ: begin
        cmd.op    = aabb_pkg::OP_ADD_Z;
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.op    = aabb_pkg::OP_CLAMP;
        state_nxt = S_EMIT;
      end
      S_ODIFF: begin
        cmd.op    = aabb_pkg::OP_OBS_DIFF;
        state_nxt = S_OTEST;
      end
      S_OTEST: begin
        cmd.op    = aabb_pkg::OP_OBS_TEST;
        state_nxt = S_OPUSH;
      end
      S_OPUSH: begin
        cmd.op    = aabb_pkg::OP_OBS_PUSH;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // hold while the previous result still waits
        if (!status.out_hold) begin
          cmd.op    = aabb_pkg::OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### rtl/aabb_dp.sv
// Body state, shared multiplier, clamp and box resolve datapath.
`timescale 1ns / 1ps

module aabb_dp (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  aabb_pkg::cmd_t                           cmd,
  input  aabb_pkg::cfg_t                           cfg,
  output aabb_pkg::status_t                        status,
  input  logic [aabb_pkg::DT_W-1:0]                in_dt,
  input  logic signed [aabb_pkg::VALUE_BITS-1:0]   in_obstacle_x,
  input  logic signed [aabb_pkg::VALUE_BITS-1:0]   in_obstacle_y,
  input  logic signed [aabb_pkg::VALUE_BITS-1:0]   in_obstacle_z,
  input  logic [aabb_pkg::SIZE_W-1:0]              in_obstacle_size_x,
  input  logic [aabb_pkg::SIZE_W-1:0]              in_obstacle_size_y,
  input  logic [aabb_pkg::SIZE_W-1:0]              in_obstacle_size_z,
  input  logic                                     out_stall,
  output logic                                     out_valid,
  output logic signed [aabb_pkg::VALUE_BITS-1:0]   out_body_x,
  output logic signed [aabb_pkg::VALUE_BITS-1:0]   out_body_y,
  output logic signed [aabb_pkg::VALUE_BITS-1:0]   out_body_z,
  output logic signed [aabb_pkg::VALUE_BITS-1:0]   out_speed_x,
  output logic signed [aabb_pkg::VALUE_BITS-1:0]   out_speed_y,
  output logic signed [aabb_pkg::VALUE_BITS-1:0]   out_speed_z,
  output logic                                     out_hit
);

  localparam int VB  = aabb_pkg::VALUE_BITS;
  localparam int SW  = aabb_pkg::SUM_W;
  localparam int DW  = aabb_pkg::DIFF_W;
  localparam int SPW = aabb_pkg::SPAN_W;

  // body state
  logic signed [VB-1:0] px_r, py_r, pz_r, vx_r, vy_r, vz_r;
  logic                 hit_r;

  // item registers
  logic [aabb_pkg::DT_W-1:0]   dt_r;
  logic signed [VB-1:0]        ox_r, oy_r, oz_r;
  logic [aabb_pkg::SIZE_W-1:0] szx_r, szy_r, szz_r;

  // working registers
  logic signed [aabb_pkg::PROD_W-1:0] prod_r;
  logic [DW-1:0]                      dx_r, dy_r, dz_r;
  logic [SPW-1:0]                     sx_r, sy_r, sz_r;
  logic [SPW-1:0]                     ovx_r, ovy_r, ovz_r;

  // output registers
  logic                 out_valid_r, out_valid_nxt;
  logic signed [VB-1:0] obx_r, oby_r, obz_r, osx_r, osy_r, osz_r;
  logic                 ohit_r;

  logic signed [aabb_pkg::MUL_A_W-1:0] mul_a;
  logic signed [aabb_pkg::PROD_W-1:0]  mul_p, prod_sh;
  logic signed [VB-1:0]                acc_pos, vy_dec, pos_add;
  logic signed [SW-1:0]                lim_raw, lim, neg_lim, ground_ext;
  logic signed [VB-1:0]                ground_sat, lim_v, neg_lim_v;
  logic                                y_low, x_hi, x_lo, z_hi, z_lo;
  logic signed [DW-1:0]                diff_x, diff_y, diff_z;
  logic [DW-1:0]                       abs_x, abs_y, abs_z;
  logic [SPW-1:0]                      span_x, span_y, span_z;
  logic                                overlap;
  logic                                sel_x, sel_y;
  logic signed [VB-1:0]                push_p, push_o, push_res;
  logic [SPW-1:0]                      push_ov;
  logic signed [SW-1:0]                push_d;

  assign status.out_hold = out_valid_r && out_stall;

  // Shared multiplier: operand follows the step
  always_comb begin
    case (cmd.op)
      aabb_pkg::OP_GRAV:  mul_a = aabb_pkg::MUL_A_W'($signed({1'b0, cfg.gravity}));
      aabb_pkg::OP_VEL_X: mul_a = aabb_pkg::MUL_A_W'(vx_r);
      aabb_pkg::OP_VEL_Y: mul_a = aabb_pkg::MUL_A_W'(vy_r);
      aabb_pkg::OP_VEL_Z: mul_a = aabb_pkg::MUL_A_W'(vz_r);
      default:            mul_a = '0;
    endcase
  end

  assign mul_p   = mul_a * $signed({1'b0, dt_r});
  assign prod_sh = prod_r >>> aabb_pkg::FRAC_BITS;

  always_comb begin
    case (cmd.op)
      aabb_pkg::OP_VEL_Y: acc_pos = px_r;
      aabb_pkg::OP_VEL_Z: acc_pos = py_r;
      default:            acc_pos = pz_r;
    endcase
  end

  assign vy_dec  = aabb_pkg::sat_val(SW'(vy_r) - SW'(prod_sh));
  assign pos_add = aabb_pkg::sat_val(SW'(acc_pos) + SW'(prod_sh));

  // Clamp bounds
  assign lim_raw    = SW'({1'b0, cfg.world_limit});
  assign lim        = (lim_raw > aabb_pkg::VMAX_S) ? aabb_pkg::VMAX_S : lim_raw;
  assign neg_lim    = -lim;
  assign lim_v      = lim[VB-1:0];
  assign neg_lim_v  = neg_lim[VB-1:0];
  assign ground_ext = SW'($signed(cfg.ground_level));
  assign ground_sat = aabb_pkg::sat_val(ground_ext);
  assign y_low      = SW'(py_r) < ground_ext;
  assign x_hi       = SW'(px_r) > lim;
  assign x_lo       = SW'(px_r) < neg_lim;
  assign z_hi       = SW'(pz_r) > lim;
  assign z_lo       = SW'(pz_r) < neg_lim;

  // Box distance and combined half extent per axis
  assign diff_x = DW'(px_r) - DW'(ox_r);
  assign diff_y = DW'(py_r) - DW'(oy_r);
  assign diff_z = DW'(pz_r) - DW'(oz_r);
  assign abs_x  = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
  assign abs_y  = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
  assign abs_z  = diff_z[DW-1] ? DW'(-diff_z) : DW'(diff_z);
  assign span_x = SPW'(cfg.body_half_x) + SPW'(szx_r >> 1);
  assign span_y = SPW'(cfg.body_half_y) + SPW'(szy_r >> 1);
  assign span_z = SPW'(cfg.body_half_z) + SPW'(szz_r >> 1);

  assign overlap = (SW'(dx_r) < SW'(sx_r)) && (SW'(dy_r) < SW'(sy_r)) &&
                   (SW'(dz_r) < SW'(sz_r));

  // Least-overlap axis, ties go to z
  assign sel_x = (ovx_r < ovy_r) && (ovx_r < ovz_r);
  assign sel_y = !sel_x && (ovy_r < ovx_r) && (ovy_r < ovz_r);

  always_comb begin
    if (sel_x) begin
      push_p  = px_r;
      push_o  = ox_r;
      push_ov = ovx_r;
    end else if (sel_y) begin
      push_p  = py_r;
      push_o  = oy_r;
      push_ov = ovy_r;
    end else begin
      push_p  = pz_r;
      push_o  = oz_r;
      push_ov = ovz_r;
    end
  end

  assign push_d   = SW'(push_ov >> 1);
  assign push_res = (push_p < push_o) ? aabb_pkg::sat_val(SW'(push_p) - push_d)
                                      : aabb_pkg::sat_val(SW'(push_p) + push_d);

  // Item and working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dt_r  <= in_dt;
      ox_r  <= in_obstacle_x;
      oy_r  <= in_obstacle_y;
      oz_r  <= in_obstacle_z;
      szx_r <= in_obstacle_size_x;
      szy_r <= in_obstacle_size_y;
      szz_r <= in_obstacle_size_z;
    end
    case (cmd.op)
      aabb_pkg::OP_GRAV, aabb_pkg::OP_VEL_X, aabb_pkg::OP_VEL_Y, aabb_pkg::OP_VEL_Z: begin
        prod_r <= mul_p;
      end
      aabb_pkg::OP_OBS_DIFF: begin
        dx_r <= abs_x;
        dy_r <= abs_y;
        dz_r <= abs_z;
        sx_r <= span_x;
        sy_r <= span_y;
        sz_r <= span_z;
      end
      aabb_pkg::OP_OBS_TEST: begin
        ovx_r <= SPW'(SW'(sx_r) - SW'(dx_r));
        ovy_r <= SPW'(SW'(sy_r) - SW'(dy_r));
        ovz_r <= SPW'(SW'(sz_r) - SW'(dz_r));
      end
      default: begin
      end
    endcase
    if (cmd.op == aabb_pkg::OP_EMIT) begin
      obx_r  <= px_r;
      oby_r  <= py_r;
      obz_r  <= pz_r;
      osx_r  <= vx_r;
      osy_r  <= vy_r;
      osz_r  <= vz_r;
      ohit_r <= hit_r;
    end
  end

  // Body state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r  <= '0;
      py_r  <= '0;
      pz_r  <= '0;
      vx_r  <= '0;
      vy_r  <= '0;
      vz_r  <= '0;
      hit_r <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        hit_r <= 1'b0;
      end
      case (cmd.op)
        aabb_pkg::OP_VEL_X: vy_r <= vy_dec;
        aabb_pkg::OP_VEL_Y: px_r <= pos_add;
        aabb_pkg::OP_VEL_Z: py_r <= pos_add;
        aabb_pkg::OP_ADD_Z: pz_r <= pos_add;
        aabb_pkg::OP_CLAMP: begin
          if (y_low) begin
            py_r <= ground_sat;
            vy_r <= '0;
          end
          if (x_hi) begin
            px_r <= lim_v;
            vx_r <= '0;
          end else if (x_lo) begin
            px_r <= neg_lim_v;
            vx_r <= '0;
          end
          if (z_hi) begin
            pz_r <= lim_v;
            vz_r <= '0;
          end else if (z_lo) begin
            pz_r <= neg_lim_v;
            vz_r <= '0;
          end
        end
        aabb_pkg::OP_OBS_TEST: hit_r <= overlap;
        aabb_pkg::OP_OBS_PUSH: begin
          if (hit_r) begin
            if (sel_x) begin
              px_r <= push_res;
            end else if (sel_y) begin
              py_r <= push_res;
            end else begin
              pz_r <= push_res;
            end
            vx_r <= vx_r >>> 1;
            vz_r <= vz_r >>> 1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output beat valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.op == aabb_pkg::OP_EMIT) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_body_x  = obx_r;
  assign out_body_y  = oby_r;
  assign out_body_z  = obz_r;
  assign out_speed_x = osx_r;
  assign out_speed_y = osy_r;
  assign out_speed_z = osz_r;
  assign out_hit     = ohit_r;

endmodule

### rtl/aabb_body_step_and_resolve_unit.sv
// Top level of the AABB body step and resolve unit.
`timescale 1ns / 1ps

// Keeps one body's position and velocity in signed Q7.12 and answers every
// input beat with exactly one result beat carrying the state after the item.
// A tick beat (kind 0) applies gravity*dt to the y velocity, velocity*dt to
// the position, then clamps y to the ground and x/z to the world limit,
// zeroing the matching velocity. An obstacle beat (kind 1) tests the body box
// against the given box; on strict overlap on all three axes it pushes the
// body out by half the overlap along the least-overlap axis (ties go to z),
// halves x and z velocity and sets hit. Products truncate toward minus
// infinity and state updates saturate. One item is in work at a time: the
// input stays stalled from acceptance until the result is loaded, so the
// block takes no new item before it is through with the last one. A tick
// runs four dependent products through one shared 21x13 multiplier, then a
// final add, a clamp and an output load step; an obstacle runs the
// distance, overlap and push steps plus the output load. The result sits in
// an output register, so the block goes back to accepting once it is loaded;
// when a previous result is still stalled, the new one waits and the input
// stays stalled. The user must write registers over the cfg_ port only while
// the block is idle; the block itself does not enforce this.

module aabb_body_step_and_resolve_unit (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // input channel
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic                                     in_kind,
  input  logic [aabb_pkg::DT_W-1:0]                in_dt,
  input  logic signed [aabb_pkg::VALUE_BITS-1:0]   in_obstacle_x,
  input  logic signed [aabb_pkg::VALUE_BITS-1:0]   in_obstacle_y,
  input  logic signed [aabb_pkg::VALUE_BITS-1:0]   in_obstacle_z,
  input  logic [aabb_pkg::SIZE_W-1:0]              in_obstacle_size_x,
  input  logic [aabb_pkg::SIZE_W-1:0]              in_obstacle_size_y,
  input  logic [aabb_pkg::SIZE_W-1:0]              in_obstacle_size_z,
  // result channel
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [aabb_pkg::VALUE_BITS-1:0]   out_body_x,
  output logic signed [aabb_pkg::VALUE_BITS-1:0]   out_body_y,
  output logic signed [aabb_pkg::VALUE_BITS-1:0]   out_body_z,
  output logic signed [aabb_pkg::VALUE_BITS-1:0]   out_speed_x,
  output logic signed [aabb_pkg::VALUE_BITS-1:0]   out_speed_y,
  output logic signed [aabb_pkg::VALUE_BITS-1:0]   out_speed_z,
  output logic                                     out_hit,
  // register port
  input  logic                                     cfg_psel,
  input  logic                                     cfg_penable,
  input  logic                                     cfg_pwrite,
  input  logic [aabb_pkg::ADDR_W-1:0]              cfg_paddr,
  input  logic [aabb_pkg::DATA_W-1:0]              cfg_pwdata,
  output logic [aabb_pkg::DATA_W-1:0]              cfg_prdata,
  output logic                                     cfg_pready
);

  aabb_pkg::cfg_t    cfg;
  aabb_pkg::cmd_t    cmd;
  aabb_pkg::status_t status;
  logic              busy;

  // Input is taken only while the sequencer is idle
  assign in_stall = busy;

  aabb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Sequencer: picks the step list from the kind of the accepted beat
  aabb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .status   (status),
    .busy     (busy),
    .cmd      (cmd)
  );

  // Datapath: body state, shared multiplier, resolve logic, output register
  aabb_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg                (cfg),
    .status             (status),
    .in_dt              (in_dt),
    .in_obstacle_x      (in_obstacle_x),
    .in_obstacle_y      (in_obstacle_y),
    .in_obstacle_z      (in_obstacle_z),
    .in_obstacle_size_x (in_obstacle_size_x),
    .in_obstacle_size_y (in_obstacle_size_y),
    .in_obstacle_size_z (in_obstacle_size_z),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_body_x         (out_body_x),
    .out_body_y         (out_body_y),
    .out_body_z         (out_body_z),
    .out_speed_x        (out_speed_x),
    .out_speed_y        (out_speed_y),
    .out_speed_z        (out_speed_z),
    .out_hit            (out_hit)
  );

  // An accepted beat always makes the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted but block not busy afterwards");

  // A new result never overwrites one that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == aabb_pkg::OP_EMIT) |-> !(out_valid && out_stall))
    else $error("result loaded over a stalled beat");

  // A result beat only appears after the emit step
  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.op == aabb_pkg::OP_EMIT))
    else $error("result beat without an emit step");

endmodule
